// ===== src/assert_macros.svh =====
// assertion macros for the damped cosine grid weight checks
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define DCGW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dcgw port check failed");

// property checked at every edge, reset included
`define DCGW_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("dcgw reset check failed");

`endif

// ===== src/dcgw_pkg.sv =====
// shared constants, types and table functions for the damped cosine grid weight
// no dependencies
`default_nettype none

package dcgw_pkg;

    localparam int INDEX_BITS_DEF = 20;
    localparam int TABLE_BITS_DEF = 10;

    localparam int NUM_DIMS     = 3;
    localparam int HORNER_TERMS = 12;
    localparam int SQUARINGS    = 5;

    localparam int FRONT_STAGES = 4;
    localparam int EXP_STAGES   = 2 * HORNER_TERMS + SQUARINGS;
    localparam int MUL_STAGES   = 2 * NUM_DIMS + 1;
    localparam int PIPE_STAGES  = FRONT_STAGES + EXP_STAGES + MUL_STAGES;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [63:0] Q30_ONE64   = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] DECAY_LIMIT = 64'd24 << 24;

    localparam logic [17:0] WEIGHT_MAX  = 18'd65536;

    typedef enum logic [2:0] {
        REG_ACTIVE_DIMS = 3'd0,
        REG_SIZE_LOG2_X = 3'd1,
        REG_SIZE_LOG2_Y = 3'd2,
        REG_RATES_X     = 3'd3,
        REG_RATES_Y     = 3'd4,
        REG_RATES_Z     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]                    active_dims;
        logic [4:0]                    size_log2_x;
        logic [4:0]                    size_log2_y;
        logic [NUM_DIMS-1:0][63:0]     rates;
    } dcgw_cfg_t;

    typedef struct packed {
        logic                          last;
        logic                          neg;
        logic [NUM_DIMS-1:0][30:0]     cmag;
    } dcgw_side_t;

    typedef struct packed {
        logic [NUM_DIMS-1:0]           zero;
        logic [NUM_DIMS-1:0][29:0]     y;
    } dcgw_exp_in_t;

    // ceil(2^34 / n), exact quotient for dividends below 2^30
    localparam logic [34:0] EXP_RECIP [1:HORNER_TERMS] = '{
        35'(((64'd1 << 34) + 64'd0) / 64'd1),
        35'(((64'd1 << 34) + 64'd1) / 64'd2),
        35'(((64'd1 << 34) + 64'd2) / 64'd3),
        35'(((64'd1 << 34) + 64'd3) / 64'd4),
        35'(((64'd1 << 34) + 64'd4) / 64'd5),
        35'(((64'd1 << 34) + 64'd5) / 64'd6),
        35'(((64'd1 << 34) + 64'd6) / 64'd7),
        35'(((64'd1 << 34) + 64'd7) / 64'd8),
        35'(((64'd1 << 34) + 64'd8) / 64'd9),
        35'(((64'd1 << 34) + 64'd9) / 64'd10),
        35'(((64'd1 << 34) + 64'd10) / 64'd11),
        35'(((64'd1 << 34) + 64'd11) / 64'd12)
    };

    // ceil(2^40 / (n * (n - 1))) for n = 14 down to 2, exact for dividends below 2^32
    localparam logic [40:0] COS_RECIP [7] = '{
        41'(((64'd1 << 40) + 64'd181) / 64'd182),
        41'(((64'd1 << 40) + 64'd131) / 64'd132),
        41'(((64'd1 << 40) + 64'd89) / 64'd90),
        41'(((64'd1 << 40) + 64'd55) / 64'd56),
        41'(((64'd1 << 40) + 64'd29) / 64'd30),
        41'(((64'd1 << 40) + 64'd11) / 64'd12),
        41'(((64'd1 << 40) + 64'd1) / 64'd2)
    };

    function automatic logic [30:0] horner_clamp(input logic [30:0] sub);
        return (sub >= Q30_ONE) ? 31'd0 : Q30_ONE - sub;
    endfunction

    // first quadrant cosine in q30, evaluated at elaboration only
    function automatic logic [30:0] cos_q30(input logic [63:0] r, input int tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] b;
        logic [63:0] a;
        logic [63:0] sub;
        logic [95:0] prod;
        x   = (r * TWO_PI_Q30) >> tb;
        x2  = (x * x) >> 30;
        b   = Q30_ONE64;
        for (int i = 0; i < 7; i++) begin
            a    = (x2 * b) >> 30;
            prod = 96'(a) * 96'(COS_RECIP[i]);
            sub  = 64'(prod >> 40);
            b    = (sub >= Q30_ONE64) ? 64'd0 : Q30_ONE64 - sub;
        end
        if (b > Q30_ONE64) begin
            b = Q30_ONE64;
        end
        return 31'(b);
    endfunction

endpackage

`default_nettype wire

// ===== src/dcgw_front.sv =====
// front stages: index split, phase and decay products, cosine table lookup
// depends on dcgw_pkg
`default_nettype none

module dcgw_front #(
    parameter int INDEX_BITS = dcgw_pkg::INDEX_BITS_DEF,
    parameter int TABLE_BITS = dcgw_pkg::TABLE_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic [dcgw_pkg::FRONT_STAGES-1:0]      stage_en,
    input  wire dcgw_pkg::dcgw_cfg_t                    cfg,
    input  wire logic [INDEX_BITS-1:0]                  idx,
    input  wire logic                                   last_in,
    output dcgw_pkg::dcgw_side_t                        side_out,
    output dcgw_pkg::dcgw_exp_in_t                      exp_out
);

    localparam int ND      = dcgw_pkg::NUM_DIMS;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int ADDR_W  = TABLE_BITS - 1;
    localparam logic [INDEX_BITS-1:0] ONES = '1;
    localparam logic [32:0] ROUND_T = 33'd1 << (31 - TABLE_BITS);

    logic [30:0] cos_rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
        localparam logic [30:0] ROM_VAL = dcgw_pkg::cos_q30(64'(g), TABLE_BITS);
        assign cos_rom[g] = ROM_VAL;
    end

    // stage 0: split
    logic [ND-1:0][INDEX_BITS-1:0] k_next, k_reg;
    logic                          last0_reg;
    logic [5:0]                    shift_sum;

    always_comb begin
        shift_sum = 6'(cfg.size_log2_x) + 6'(cfg.size_log2_y);
        k_next[0] = idx & ~(ONES << cfg.size_log2_x);
        k_next[1] = (idx >> cfg.size_log2_x) & ~(ONES << cfg.size_log2_y);
        k_next[2] = idx >> shift_sum;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            k_reg     <= k_next;
            last0_reg <= last_in;
        end
    end

    // stage 1: phase and decay products
    logic [ND-1:0][31:0] t_next, t_reg;
    logic [ND-1:0][63:0] x_next, x_reg;
    logic                last1_reg;

    always_comb begin
        for (int l = 0; l < ND; l++) begin
            t_next[l] = 32'(cfg.rates[l][63:32] * 32'(k_reg[l]));
            x_next[l] = 64'(cfg.rates[l][31:0]) * 64'(k_reg[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            t_reg     <= t_next;
            x_reg     <= x_next;
            last1_reg <= last0_reg;
        end
    end

    // stage 2: quadrant fold and decay limit
    logic [ND-1:0][ADDR_W-1:0] addr_next, addr_reg;
    logic [ND-1:0][29:0]       y2_next, y2_reg;
    logic [ND-1:0]             z2_next, z2_reg;
    logic                      neg2_next, neg2_reg;
    logic                      last2_reg;

    always_comb begin
        logic [32:0]           tsum;
        logic [TABLE_BITS-1:0] q;
        logic [1:0]            quad;
        logic [ADDR_W-1:0]     r;
        neg2_next = 1'b0;
        for (int l = 0; l < ND; l++) begin
            tsum = {1'b0, t_reg[l]} + ROUND_T;
            q    = tsum[31 -: TABLE_BITS];
            quad = q[TABLE_BITS-1 -: 2];
            r    = ADDR_W'(q[TABLE_BITS-3:0]);
            addr_next[l] = quad[0] ? ADDR_W'(QUARTER) - r : r;
            if (cfg.active_dims > 2'(l)) begin
                neg2_next = neg2_next ^ (quad[1] ^ quad[0]);
            end
            z2_next[l] = (x_reg[l] >= dcgw_pkg::DECAY_LIMIT);
            y2_next[l] = z2_next[l] ? 30'd0 : {x_reg[l][28:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            addr_reg  <= addr_next;
            y2_reg    <= y2_next;
            z2_reg    <= z2_next;
            neg2_reg  <= neg2_next;
            last2_reg <= last1_reg;
        end
    end

    // stage 3: table read
    logic [ND-1:0][30:0] cmag_next, cmag_reg;
    logic [ND-1:0][29:0] y3_reg;
    logic [ND-1:0]       z3_reg;
    logic                neg3_reg;
    logic                last3_reg;

    always_comb begin
        for (int l = 0; l < ND; l++) begin
            cmag_next[l] = cos_rom[addr_reg[l]];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            cmag_reg  <= cmag_next;
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
            neg3_reg  <= neg2_reg;
            last3_reg <= last2_reg;
        end
    end

    assign side_out.last = last3_reg;
    assign side_out.neg  = neg3_reg;
    assign side_out.cmag = cmag_reg;
    assign exp_out.zero  = z3_reg;
    assign exp_out.y     = y3_reg;

endmodule

`default_nettype wire

// ===== src/dcgw_exp.sv =====
// decay factor pipeline: horner series steps and repeated squaring per lane
// depends on dcgw_pkg
`default_nettype none

module dcgw_exp (
    input  wire logic                                 aclk,
    input  wire logic [dcgw_pkg::EXP_STAGES-1:0]      stage_en,
    input  wire dcgw_pkg::dcgw_exp_in_t               exp_in,
    input  wire dcgw_pkg::dcgw_side_t                 side_in,
    output logic [dcgw_pkg::NUM_DIMS-1:0][30:0]       efac,
    output dcgw_pkg::dcgw_side_t                      side_out
);

    localparam int ND = dcgw_pkg::NUM_DIMS;
    localparam int NS = dcgw_pkg::EXP_STAGES;
    localparam int HT = dcgw_pkg::HORNER_TERMS;

    logic [ND-1:0][30:0]  val_reg  [NS];
    logic [ND-1:0][29:0]  y_reg    [NS];
    logic [ND-1:0]        z_reg    [NS];
    dcgw_pkg::dcgw_side_t side_reg [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [ND-1:0][30:0]  v_src, val_next;
        logic [ND-1:0][29:0]  y_src;
        logic [ND-1:0]        z_src;
        dcgw_pkg::dcgw_side_t side_src;

        if (j == 0) begin : g_first
            assign v_src    = {ND{dcgw_pkg::Q30_ONE}};
            assign y_src    = exp_in.y;
            assign z_src    = exp_in.zero;
            assign side_src = side_in;
        end else begin : g_next
            assign v_src    = val_reg[j-1];
            assign y_src    = y_reg[j-1];
            assign z_src    = z_reg[j-1];
            assign side_src = side_reg[j-1];
        end

        if (j < 2 * HT && j % 2 == 0) begin : g_mul
            // y * b
            always_comb begin
                logic [30:0] b_in;
                logic [60:0] prod;
                for (int l = 0; l < ND; l++) begin
                    b_in = (j == 0) ? v_src[l] : dcgw_pkg::horner_clamp(v_src[l]);
                    prod = 61'(y_src[l]) * 61'(b_in);
                    val_next[l] = 31'(prod >> 30);
                end
            end
        end else if (j < 2 * HT) begin : g_div
            // divide by the term index through its reciprocal
            localparam int N = HT - j / 2;
            always_comb begin
                logic [65:0] prod;
                for (int l = 0; l < ND; l++) begin
                    prod = 66'(v_src[l]) * 66'(dcgw_pkg::EXP_RECIP[N]);
                    val_next[l] = 31'(prod >> 34);
                end
            end
        end else begin : g_sq
            always_comb begin
                logic [30:0] b_in;
                logic [61:0] prod;
                for (int l = 0; l < ND; l++) begin
                    b_in = (j == 2 * HT) ? dcgw_pkg::horner_clamp(v_src[l]) : v_src[l];
                    prod = 62'(b_in) * 62'(b_in) + (62'd1 << 29);
                    val_next[l] = 31'(prod >> 30);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[j]) begin
                val_reg[j]  <= val_next;
                y_reg[j]    <= y_src;
                z_reg[j]    <= z_src;
                side_reg[j] <= side_src;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < ND; l++) begin
            efac[l] = z_reg[NS-1][l] ? 31'd0 : val_reg[NS-1][l];
        end
    end

    assign side_out = side_reg[NS-1];

endmodule

`default_nettype wire

// ===== src/dcgw_mul.sv =====
// product of the factors in order, then rounding and saturation to q1.16
// depends on dcgw_pkg
`default_nettype none

module dcgw_mul (
    input  wire logic                                 aclk,
    input  wire logic [dcgw_pkg::MUL_STAGES-1:0]      stage_en,
    input  wire logic [1:0]                           active_dims,
    input  wire logic [dcgw_pkg::NUM_DIMS-1:0][30:0]  efac,
    input  wire dcgw_pkg::dcgw_side_t                 side_in,
    output logic signed [17:0]                        weight,
    output logic                                      last_weight
);

    localparam int ND = dcgw_pkg::NUM_DIMS;
    localparam int NM = 2 * ND;

    logic [30:0]          acc_reg  [NM];
    logic [ND-1:0][30:0]  e_reg    [NM];
    dcgw_pkg::dcgw_side_t side_reg [NM];

    for (genvar i = 0; i < NM; i++) begin : g_stage
        logic [30:0]          acc_src, acc_next, fac;
        logic [ND-1:0][30:0]  e_src;
        dcgw_pkg::dcgw_side_t side_src;
        logic [61:0]          prod;

        if (i == 0) begin : g_first
            assign acc_src  = dcgw_pkg::Q30_ONE;
            assign e_src    = efac;
            assign side_src = side_in;
        end else begin : g_next
            assign acc_src  = acc_reg[i-1];
            assign e_src    = e_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        if (i % 2 == 0) begin : g_cos
            assign fac = side_src.cmag[i/2];
        end else begin : g_dec
            assign fac = e_src[i/2];
        end

        always_comb begin
            prod     = 62'(acc_src) * 62'(fac) + (62'd1 << 29);
            acc_next = (active_dims > 2'(i / 2)) ? 31'(prod >> 30) : acc_src;
        end

        always_ff @(posedge aclk) begin
            if (stage_en[i]) begin
                acc_reg[i]  <= acc_next;
                e_reg[i]    <= e_src;
                side_reg[i] <= side_src;
            end
        end
    end

    // output rounding
    logic [31:0]        wsum;
    logic [17:0]        wmag;
    logic signed [17:0] weight_next, weight_reg;
    logic               last_reg;

    always_comb begin
        wsum = 32'(acc_reg[NM-1]) + 32'h2000;
        wmag = 18'(wsum >> 14);
        if (wmag > dcgw_pkg::WEIGHT_MAX) begin
            wmag = dcgw_pkg::WEIGHT_MAX;
        end
        weight_next = (side_reg[NM-1].neg && wmag != 18'd0) ? -$signed(wmag) : $signed(wmag);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[NM]) begin
            weight_reg <= weight_next;
            last_reg   <= side_reg[NM-1].last;
        end
    end

    assign weight      = weight_reg;
    assign last_weight = last_reg;

endmodule

`default_nettype wire

// ===== src/damped_cosine_grid_weight.sv =====
// damped cosine grid weight: top level, configuration registers, pipeline valids
// depends on dcgw_pkg, dcgw_front, dcgw_exp, dcgw_mul
//
// usage
// - s_axis carries one packed grid index per request (tdata), tlast marks the
//   last point of a set; m_axis returns one signed q1.16 weight per request
//   in tdata bits 17..0, with tlast copied from the request
// - cfg_wr_en / cfg_index / cfg_wdata write the six registers, only while idle
// - fully pipelined: one request per cycle unless m_axis_tready stalls the output, 40
//   register stages; most of the depth comes from the twelve horner steps of the
//   decay series (multiply and reciprocal stage each) and five squarings
// - every stage holds a valid bit; when m_axis_tready is low the empty stages
//   still fill, so requests are accepted until the pipeline is full, and
//   nothing is lost or repeated
// - aresetn (synchronous, active low) empties the pipeline and sets
//   active_dims to 1, sizes and rates to 0
`default_nettype none

module damped_cosine_grid_weight #(
    parameter int INDEX_BITS = dcgw_pkg::INDEX_BITS_DEF,
    parameter int TABLE_BITS = dcgw_pkg::TABLE_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [((INDEX_BITS+7)/8)*8-1:0]     s_axis_tdata,  // grid_index
    input  wire logic                                s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [23:0]                              m_axis_tdata,  // weight
    output logic                                     m_axis_tlast,
    input  wire logic                                cfg_wr_en,
    input  wire logic [2:0]                          cfg_index,
    input  wire logic [63:0]                         cfg_wdata
);

    localparam int NP     = dcgw_pkg::PIPE_STAGES;
    localparam int EXP_LO = dcgw_pkg::FRONT_STAGES;
    localparam int MUL_LO = EXP_LO + dcgw_pkg::EXP_STAGES;

    dcgw_pkg::dcgw_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (dcgw_pkg::cfg_reg_t'(cfg_index))
                dcgw_pkg::REG_ACTIVE_DIMS: cfg_next.active_dims = cfg_wdata[1:0];
                dcgw_pkg::REG_SIZE_LOG2_X: cfg_next.size_log2_x = cfg_wdata[4:0];
                dcgw_pkg::REG_SIZE_LOG2_Y: cfg_next.size_log2_y = cfg_wdata[4:0];
                dcgw_pkg::REG_RATES_X:     cfg_next.rates[0]    = cfg_wdata;
                dcgw_pkg::REG_RATES_Y:     cfg_next.rates[1]    = cfg_wdata;
                dcgw_pkg::REG_RATES_Z:     cfg_next.rates[2]    = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_dims <= 2'd1;
            cfg_reg.size_log2_x <= 5'd0;
            cfg_reg.size_log2_y <= 5'd0;
            cfg_reg.rates       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // valid bits and stage enables, bubbles close up under stall
    logic [NP-1:0] valid_reg, valid_next, stage_en;

    assign stage_en[NP-1] = !valid_reg[NP-1] || m_axis_tready;
    for (genvar i = 0; i < NP - 1; i++) begin : g_en
        assign stage_en[i] = !valid_reg[i] || stage_en[i+1];
    end

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int i = 1; i < NP; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    dcgw_pkg::dcgw_side_t                      side_front, side_exp;
    dcgw_pkg::dcgw_exp_in_t                    exp_in;
    logic [dcgw_pkg::NUM_DIMS-1:0][30:0]       efac;
    logic signed [17:0]                        weight;
    logic                                      last_weight;

    dcgw_front #(
        .INDEX_BITS (INDEX_BITS),
        .TABLE_BITS (TABLE_BITS)
    ) u_front (
        .aclk     (aclk),
        .stage_en (stage_en[EXP_LO-1:0]),
        .cfg      (cfg_reg),
        .idx      (s_axis_tdata[INDEX_BITS-1:0]),
        .last_in  (s_axis_tlast),
        .side_out (side_front),
        .exp_out  (exp_in)
    );

    dcgw_exp u_exp (
        .aclk     (aclk),
        .stage_en (stage_en[MUL_LO-1:EXP_LO]),
        .exp_in   (exp_in),
        .side_in  (side_front),
        .efac     (efac),
        .side_out (side_exp)
    );

    dcgw_mul u_mul (
        .aclk        (aclk),
        .stage_en    (stage_en[NP-1:MUL_LO]),
        .active_dims (cfg_reg.active_dims),
        .efac        (efac),
        .side_in     (side_exp),
        .weight      (weight),
        .last_weight (last_weight)
    );

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[NP-1];
    assign m_axis_tdata  = {6'd0, weight};
    assign m_axis_tlast  = last_weight;

endmodule

`default_nettype wire

// ===== src/dcgw_port_check.sv =====
// port level checks for the damped cosine grid weight, bound to the top level
// depends on assert_macros.svh and damped_cosine_grid_weight
`default_nettype none
`include "assert_macros.svh"

module dcgw_port_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    `DCGW_ASSERT(a_weight_range, aclk, aresetn, m_axis_tvalid |-> ($signed(m_axis_tdata[17:0]) <= 18'sd65536 && $signed(m_axis_tdata[17:0]) >= -18'sd65536))
    `DCGW_ASSERT(a_pad_zero, aclk, aresetn, m_axis_tvalid |-> (m_axis_tdata[23:18] == 6'd0))
    `DCGW_ASSERT(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid |-> s_axis_tready)
    `DCGW_ASSERT(a_hold, aclk, aresetn, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    `DCGW_ASSERT_ALL(a_reset_empty, aclk, !aresetn |=> !m_axis_tvalid)

endmodule

bind damped_cosine_grid_weight dcgw_port_check u_port_check (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/dcgw_checker.sv =====
// checker for damped_cosine_grid_weight: mirrors the register writes, predicts each weight
// and compares it with the m_axis stream; depends on dcgw_pkg
module dcgw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // grid_index
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // weight
    input  logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          n_pending,
    output int          n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] data;
        logic        last;
    } weight_t;

    weight_t     weight_q[$];
    logic [1:0]  dims;
    logic [4:0]  lg_x;
    logic [4:0]  lg_y;
    logic [63:0] rate_x;
    logic [63:0] rate_y;
    logic [63:0] rate_z;

    function automatic logic [63:0] cos_quarter(input logic [63:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] b;
        logic [63:0] sub;
        x  = (r * dcgw_pkg::TWO_PI_Q30) >> 10;
        x2 = (x * x) >> 30;
        b  = dcgw_pkg::Q30_ONE64;
        for (int n = 14; n >= 2; n -= 2) begin
            sub = (x2 * b) / (64'(n * (n - 1)) << 30);
            b   = (sub >= dcgw_pkg::Q30_ONE64) ? 64'd0 : dcgw_pkg::Q30_ONE64 - sub;
        end
        return (b > dcgw_pkg::Q30_ONE64) ? dcgw_pkg::Q30_ONE64 : b;
    endfunction

    function automatic logic [63:0] decay_term(input logic [63:0] decay, input logic [63:0] k);
        logic [63:0] y;
        logic [63:0] b;
        logic [63:0] sub;
        if (k != 0 && decay > (dcgw_pkg::DECAY_LIMIT - 1) / k) begin
            return 64'd0;
        end
        y = (decay * k) << 1;
        b = dcgw_pkg::Q30_ONE64;
        for (int n = 12; n >= 1; n--) begin
            sub = (y * b) / (64'(n) << 30);
            b   = (sub >= dcgw_pkg::Q30_ONE64) ? 64'd0 : dcgw_pkg::Q30_ONE64 - sub;
        end
        for (int i = 0; i < 5; i++) begin
            b = (b * b + (64'd1 << 29)) >> 30;
        end
        return b;
    endfunction

    function automatic void damp_dim(input logic [63:0] rate, input logic [63:0] k,
                                     inout logic [63:0] acc, inout logic neg);
        logic [63:0] t;
        logic [9:0]  q;
        logic [63:0] r;
        logic [63:0] mag;
        t = (rate[63:32] * k) & 64'hFFFF_FFFF;
        q = 10'((t + (64'd1 << 21)) >> 22);
        r = 64'(q[7:0]);
        case (q[9:8])
            2'd0: mag = cos_quarter(r);
            2'd1: begin mag = cos_quarter(256 - r); neg = !neg; end
            2'd2: begin mag = cos_quarter(r); neg = !neg; end
            default: mag = cos_quarter(256 - r);
        endcase
        acc = (acc * mag + (64'd1 << 29)) >> 30;
        acc = (acc * decay_term(64'(rate[31:0]), k) + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [17:0] grid_weight(input logic [19:0] idx);
        logic [63:0] k1;
        logic [63:0] k2;
        logic [63:0] k3;
        logic [63:0] acc;
        logic [63:0] w;
        logic        neg;
        k1  = 64'(idx) & ((64'd1 << lg_x) - 1);
        k2  = (64'(idx) >> lg_x) & ((64'd1 << lg_y) - 1);
        k3  = 64'(idx) >> (6'(lg_x) + 6'(lg_y));
        acc = dcgw_pkg::Q30_ONE64;
        neg = 1'b0;
        if (dims >= 1) damp_dim(rate_x, k1, acc, neg);
        if (dims >= 2) damp_dim(rate_y, k2, acc, neg);
        if (dims >= 3) damp_dim(rate_z, k3, acc, neg);
        w = (acc + (64'd1 << 13)) >> 14;
        if (w > 65536) w = 65536;
        if (neg && w != 0) w = ~w + 1;
        return w[17:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        n_errors++;
    endtask

    always @(posedge aclk) begin
        weight_t w;
        if (!aresetn) begin
            dims      <= 2'd1;
            lg_x      <= '0;
            lg_y      <= '0;
            rate_x    <= '0;
            rate_y    <= '0;
            rate_z    <= '0;
            n_errors  = 0;
            n_pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    dcgw_pkg::REG_ACTIVE_DIMS: dims   <= cfg_wdata[1:0];
                    dcgw_pkg::REG_SIZE_LOG2_X: lg_x   <= cfg_wdata[4:0];
                    dcgw_pkg::REG_SIZE_LOG2_Y: lg_y   <= cfg_wdata[4:0];
                    dcgw_pkg::REG_RATES_X:     rate_x <= cfg_wdata;
                    dcgw_pkg::REG_RATES_Y:     rate_y <= cfg_wdata;
                    dcgw_pkg::REG_RATES_Z:     rate_z <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                weight_q.push_back('{data: {6'd0, grid_weight(s_axis_tdata[19:0])},
                                     last: s_axis_tlast});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (weight_q.size() == 0) begin
                    report_mismatch("unexpected weight", m_axis_tdata, 24'd0);
                end else begin
                    w = weight_q.pop_front();
                    if (m_axis_tdata !== w.data)
                        report_mismatch("weight", m_axis_tdata, w.data);
                    if (m_axis_tlast !== w.last)
                        report_mismatch("last", 24'(m_axis_tlast), 24'(w.last));
                end
            end
            n_pending <= weight_q.size();
        end
    end
endmodule

// ===== tb/tb_damped_cosine_grid_weight.sv =====
// testbench top for damped_cosine_grid_weight: clock, reset, register phases, index stream
// and ready pattern; depends on dcgw_pkg, dcgw_checker and the block itself
module tb_damped_cosine_grid_weight;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int RUN_CYCLES  = 600;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    int          n_pending;
    int          n_errors;
    int unsigned stall_cnt = 0;
    logic        hold_go = 1'b0;
    logic        burst = 1'b0;

    damped_cosine_grid_weight i_dut (.*);

    dcgw_checker i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("FAIL damped_cosine_grid_weight");
            $finish;
        end
    end

    // receiver: random ready, one long hold-off once started, then a stretch with no idling
    initial begin
        int unsigned hold_cnt;
        int unsigned run_cnt;
        hold_cnt = 0;
        run_cnt  = 0;
        forever begin
            @(posedge aclk);
            if (hold_go && hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                m_axis_tready <= 1'b0;
                burst         <= 1'b0;
            end else if (hold_go && run_cnt < RUN_CYCLES) begin
                run_cnt++;
                m_axis_tready <= 1'b1;
                burst         <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 36);
                burst         <= 1'b0;
            end
        end
    end

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    task automatic write_reg(input dcgw_pkg::cfg_reg_t idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic load_regs(input logic [1:0] dims, input logic [4:0] lx, input logic [4:0] ly,
                             input logic [63:0] rx, input logic [63:0] ry, input logic [63:0] rz);
        drain();
        write_reg(dcgw_pkg::REG_ACTIVE_DIMS, 64'(dims));
        write_reg(dcgw_pkg::REG_SIZE_LOG2_X, 64'(lx));
        write_reg(dcgw_pkg::REG_SIZE_LOG2_Y, 64'(ly));
        write_reg(dcgw_pkg::REG_RATES_X, rx);
        write_reg(dcgw_pkg::REG_RATES_Y, ry);
        write_reg(dcgw_pkg::REG_RATES_Z, rz);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_point(input logic [19:0] idx, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, idx};
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        if (!burst && $urandom_range(0, 99) < 36) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    function automatic logic [63:0] rand_rate();
        logic [31:0] decay;
        case ($urandom_range(0, 5))
            0: decay = 32'd0;
            1: decay = 32'hFFFF_FFFF;
            default: decay = $urandom >> $urandom_range(8, 31);
        endcase
        return {32'($urandom), decay};
    endfunction

    function automatic logic [19:0] rand_index();
        if ($urandom_range(0, 3) == 0)
            return 20'($urandom_range(0, 63));
        return 20'($urandom);
    endfunction

    initial begin
        logic [4:0] lx;
        logic [4:0] ly;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, zero rates
        send_point(20'd0, 1'b0);
        send_point(20'hFFFFF, 1'b1);
        send_point(20'h00001, 1'b0);

        // no active dimension
        load_regs(2'd0, 5'd7, 5'd7, '1, '1, '1);
        send_point(20'hABCDE, 1'b1);
        send_point(20'd0, 1'b0);

        // all dimensions, sizes at the full index width, full rates
        load_regs(2'd3, 5'd20, 5'd20, '1, '1, '1);
        send_point(20'hFFFFF, 1'b0);
        send_point(20'd1, 1'b1);
        send_point(20'd0, 1'b0);

        // quarter, half and three-quarter turns, no decay
        load_regs(2'd1, 5'd20, 5'd0, {32'h4000_0000, 32'd0}, '0, '0);
        for (int k = 0; k < 5; k++) send_point(20'(k), 1'(k == 4));

        // decay at one sixteenth of the cut-off and just under it
        load_regs(2'd2, 5'd1, 5'd19, {32'd0, 32'h0180_0000}, {32'h0123_4567, 32'h017F_FFFF}, '0);
        send_point(20'd1, 1'b0);
        send_point(20'd2, 1'b0);
        send_point(20'd3, 1'b1);

        // sizes beyond the index width
        load_regs(2'd3, 5'd31, 5'd31, rand_rate(), rand_rate(), rand_rate());
        send_point(20'h5A5A5, 1'b0);
        send_point(20'hFFFFF, 1'b1);
        load_regs(2'd3, 5'd0, 5'd25, rand_rate(), rand_rate(), rand_rate());
        send_point(20'h12345, 1'b0);
        send_point(20'hFFFFF, 1'b1);

        for (int ph = 0; ph < 11; ph++) begin
            lx = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 10));
            ly = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 10));
            load_regs(2'($urandom_range(0, 3)), lx, ly, rand_rate(), rand_rate(), rand_rate());
            // receiver hold-off while this batch is offered
            if (ph == 2) hold_go <= 1'b1;
            for (int i = 0; i < 50; i++) send_point(rand_index(), 1'($urandom));
        end

        drain();
        if (n_errors == 0 && n_pending == 0) begin
            $display("PASS damped_cosine_grid_weight");
        end else begin
            $display("FAIL damped_cosine_grid_weight");
        end
        $finish;
    end
endmodule

// ===== damped_cosine_grid_weight.f =====
+incdir+src
src/dcgw_pkg.sv
src/dcgw_front.sv
src/dcgw_exp.sv
src/dcgw_mul.sv
src/damped_cosine_grid_weight.sv
src/dcgw_port_check.sv
tb/dcgw_checker.sv
tb/tb_damped_cosine_grid_weight.sv
